FILE: src/arm_forward_kinematics_7dof_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion helpers for the forward kinematics block.
// ----------------------------------------------------------------------------
`ifndef ARM_FORWARD_KINEMATICS_7DOF_DEFINES_SVH
`define ARM_FORWARD_KINEMATICS_7DOF_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define FK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication that must hold at every clock edge outside reset.
`define FK_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: src/fk_pkg.sv
// ----------------------------------------------------------------------------
// Forward kinematics package
// Widths, register indexes, joint constants and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fk_pkg;

    localparam int NJOINT   = 7;
    localparam int ANG_W    = 16;
    localparam int LEN_W    = 17;
    localparam int POS_W    = 19;
    localparam int CS_W     = 19;
    localparam int CORD_W   = 20;
    localparam int FRAME_W  = 3;
    localparam int NSTEP    = 16;
    localparam int IDX_W    = 2;

    localparam logic [IDX_W-1:0] REG_BASE    = 2'd0;
    localparam logic [IDX_W-1:0] REG_UPPER   = 2'd1;
    localparam logic [IDX_W-1:0] REG_FOREARM = 2'd2;
    localparam logic [IDX_W-1:0] REG_TOOL    = 2'd3;

    localparam logic [LEN_W-1:0] BASE_RST    = 17'd20316;
    localparam logic [LEN_W-1:0] UPPER_RST   = 17'd26214;
    localparam logic [LEN_W-1:0] FOREARM_RST = 17'd25559;
    localparam logic [LEN_W-1:0] TOOL_RST    = 17'd5112;

    localparam logic [FRAME_W-1:0] LAST_JOINT = 3'd6;

    localparam logic signed [CORD_W-1:0] PI_Q16      = 20'sd205887;
    localparam logic signed [CORD_W-1:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic signed [CORD_W-1:0] CORDIC_K    = 20'sd39797;
    localparam logic signed [CS_W-1:0]   ONE_Q16     = 19'sd65536;
    localparam logic signed [POS_W-1:0]  POS_MAX     = 19'sd262143;
    localparam logic signed [POS_W-1:0]  POS_MIN     = -19'sd262144;

    typedef enum logic [1:0] {
        TWIST_POS,
        TWIST_NEG,
        TWIST_NONE
    } twist_t;

    typedef struct packed {
        logic [FRAME_W-1:0]     joint;
        logic signed [CS_W-1:0] cos_v;
        logic signed [CS_W-1:0] sin_v;
    } sc_t;

    function automatic logic [15:0] atan_q16(input int step);
        logic [15:0] v;
        unique case (step)
            0:       v = 16'd51472;
            1:       v = 16'd30386;
            2:       v = 16'd16055;
            3:       v = 16'd8150;
            4:       v = 16'd4091;
            5:       v = 16'd2047;
            6:       v = 16'd1024;
            7:       v = 16'd512;
            8:       v = 16'd256;
            9:       v = 16'd128;
            10:      v = 16'd64;
            11:      v = 16'd32;
            12:      v = 16'd16;
            13:      v = 16'd8;
            14:      v = 16'd4;
            default: v = 16'd2;
        endcase
        return v;
    endfunction

    function automatic twist_t twist_of(input logic [FRAME_W-1:0] joint);
        twist_t t;
        unique case (joint)
            3'd0, 3'd3, 3'd4: t = TWIST_POS;
            3'd1, 3'd2, 3'd5: t = TWIST_NEG;
            default:          t = TWIST_NONE;
        endcase
        return t;
    endfunction

endpackage

FILE: src/arm_forward_kinematics_7dof.sv
// A new transaction is taken while the last joint of the one before enters CORDIC.
// Throughput: one frame origin per cycle while the output is not stalled, set by
// the CORDIC pipeline taking one joint angle per cycle unless the queue is full.
// Reset: rst_n is asynchronous and active low; it empties the pipeline and
// queue and loads the link lengths with their default values.
// ----------------------------------------------------------------------------
// Seven-joint arm forward kinematics
// Top level: configuration registers, front end, queue and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arm_forward_kinematics_7dof
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [fk_pkg::IDX_W-1:0]          cfg_index,
    input  logic [fk_pkg::LEN_W-1:0]          cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // joint1_angle [15:0], joint2_angle .. joint7_angle [111:96], 16 bits each
    input  logic [fk_pkg::NJOINT*fk_pkg::ANG_W-1:0] s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // frame_number [2:0], pos_x [21:3], pos_y [40:22], pos_z [59:41], zero [63:60]
    output logic [63:0]                       m_axis_tdata,
    output logic                              m_axis_tlast
);
    import fk_pkg::*;

    logic [LEN_W-1:0]        base_reg;
    logic [LEN_W-1:0]        upper_reg;
    logic [LEN_W-1:0]        forearm_reg;
    logic [LEN_W-1:0]        tool_reg;
    logic                    q_full;
    logic                    q_empty;
    logic                    push;
    logic                    pop;
    sc_t                     push_sc;
    sc_t                     pop_sc;
    logic [FRAME_W-1:0]      frame_number;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg    <= BASE_RST;
            upper_reg   <= UPPER_RST;
            forearm_reg <= FOREARM_RST;
            tool_reg    <= TOOL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BASE:    base_reg    <= cfg_data;
                REG_UPPER:   upper_reg   <= cfg_data;
                REG_FOREARM: forearm_reg <= cfg_data;
                default:     tool_reg    <= cfg_data;
            endcase
        end
    end

    fk_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_data  (s_axis_tdata),
        .q_full   (q_full),
        .push     (push),
        .push_sc  (push_sc)
    );

    fk_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_sc (push_sc),
        .pop     (pop),
        .pop_sc  (pop_sc),
        .full    (q_full),
        .empty   (q_empty)
    );

    fk_back u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .empty            (q_empty),
        .pop_sc           (pop_sc),
        .pop              (pop),
        .base_height      (base_reg),
        .upper_arm_length (upper_reg),
        .forearm_length   (forearm_reg),
        .tool_length      (tool_reg),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .frame_number     (frame_number),
        .pos_x            (pos_x),
        .pos_y            (pos_y),
        .pos_z            (pos_z),
        .last_frame       (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, pos_z, pos_y, pos_x, frame_number};

endmodule

FILE: src/fk_cordic.sv
// ----------------------------------------------------------------------------
// Sine and cosine pipeline
// Folds the angle into +-pi/2 and runs a sixteen-stage rotation CORDIC.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fk_cordic
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [fk_pkg::FRAME_W-1:0]      in_joint,
    input  logic signed [fk_pkg::ANG_W-1:0] in_angle,
    output logic                            out_valid,
    output fk_pkg::sc_t                     out_sc
);
    import fk_pkg::*;

    logic                     valid_reg [0:NSTEP];
    logic [FRAME_W-1:0]       joint_reg [0:NSTEP];
    logic                     neg_reg   [0:NSTEP];
    logic signed [CORD_W-1:0] x_reg     [0:NSTEP];
    logic signed [CORD_W-1:0] y_reg     [0:NSTEP];
    logic signed [CORD_W-1:0] z_reg     [0:NSTEP];

    logic signed [CORD_W-1:0] z_in;
    logic signed [CORD_W-1:0] z_fold;
    logic                     neg_fold;
    logic signed [CORD_W-1:0] cos_full;
    logic signed [CORD_W-1:0] sin_full;

    always_comb
    begin
        z_in = {in_angle[ANG_W-1], in_angle, 3'b000};
        priority if (z_in > HALF_PI_Q16)
        begin
            z_fold   = z_in - PI_Q16;
            neg_fold = 1'b1;
        end
        else if (z_in < -HALF_PI_Q16)
        begin
            z_fold   = z_in + PI_Q16;
            neg_fold = 1'b1;
        end
        else
        begin
            z_fold   = z_in;
            neg_fold = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            joint_reg[0] <= in_joint;
            neg_reg[0]   <= neg_fold;
            x_reg[0]     <= CORDIC_K;
            y_reg[0]     <= '0;
            z_reg[0]     <= z_fold;
        end
    end

    for (genvar i = 0; i < NSTEP; i++)
    begin : g_step
        logic                     dir;
        logic signed [CORD_W-1:0] atan_v;
        logic signed [CORD_W-1:0] xs;
        logic signed [CORD_W-1:0] ys;

        always_comb
        begin
            dir    = !z_reg[i][CORD_W-1];
            atan_v = $signed({4'b0000, atan_q16(i)});
            xs     = x_reg[i] >>> i;
            ys     = y_reg[i] >>> i;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                joint_reg[i+1] <= joint_reg[i];
                neg_reg[i+1]   <= neg_reg[i];
                x_reg[i+1]     <= dir ? x_reg[i] - ys : x_reg[i] + ys;
                y_reg[i+1]     <= dir ? y_reg[i] + xs : y_reg[i] - xs;
                z_reg[i+1]     <= dir ? z_reg[i] - atan_v : z_reg[i] + atan_v;
            end
        end
    end

    always_comb
    begin
        cos_full     = neg_reg[NSTEP] ? -x_reg[NSTEP] : x_reg[NSTEP];
        sin_full     = neg_reg[NSTEP] ? -y_reg[NSTEP] : y_reg[NSTEP];
        out_valid    = valid_reg[NSTEP];
        out_sc.joint = joint_reg[NSTEP];
        out_sc.cos_v = cos_full[CS_W-1:0];
        out_sc.sin_v = sin_full[CS_W-1:0];
    end

endmodule

FILE: src/fk_front.sv
// ----------------------------------------------------------------------------
// Front end
// Takes joint-angle items; feeds one joint per cycle to CORDIC unless stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "arm_forward_kinematics_7dof_defines.svh"

module fk_front
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic [fk_pkg::NJOINT*fk_pkg::ANG_W-1:0]   in_data,
    input  logic                                      q_full,
    output logic                                      push,
    output fk_pkg::sc_t                               push_sc
);
    import fk_pkg::*;

    logic [NJOINT-1:0][ANG_W-1:0] item_reg;
    logic [FRAME_W-1:0]           cnt_reg;
    logic [FRAME_W-1:0]           cnt_next;
    logic                         busy_reg;
    logic                         busy_next;
    logic                         adv;
    logic                         cord_valid;
    logic                         take;

    fk_cordic u_cordic
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (busy_reg),
        .in_joint  (cnt_reg),
        .in_angle  ($signed(item_reg[cnt_reg])),
        .out_valid (cord_valid),
        .out_sc    (push_sc)
    );

    always_comb
    begin
        adv       = !(cord_valid && q_full);
        push      = cord_valid && adv;
        in_ready  = !busy_reg || (adv && cnt_reg == LAST_JOINT);
        take      = in_valid && in_ready;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (adv && busy_reg)
        begin
            if (cnt_reg == LAST_JOINT)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg + 3'd1;
            end
        end
        if (take)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= in_data;
        end
    end

    `FK_ASSERT_IMPL(a_ready_at_end, busy_reg && in_ready, cnt_reg == LAST_JOINT, "early accept")

endmodule

FILE: src/fk_queue.sv
// ----------------------------------------------------------------------------
// Sine and cosine queue
// Short register FIFO that decouples the CORDIC front from the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "arm_forward_kinematics_7dof_defines.svh"

module fk_queue
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  fk_pkg::sc_t push_sc,
    input  logic        pop,
    output fk_pkg::sc_t pop_sc,
    output logic        full,
    output logic        empty
);
    import fk_pkg::*;

    sc_t        mem_reg [0:3];
    logic [1:0] wr_reg;
    logic [1:0] rd_reg;
    logic [2:0] count_reg;

    always_comb
    begin
        full   = count_reg == 3'd4;
        empty  = count_reg == 3'd0;
        pop_sc = mem_reg[rd_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 2'd1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 2'd1;
            end
            count_reg <= count_reg + {2'b00, push} - {2'b00, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_sc;
        end
    end

    `FK_ASSERT(a_no_overflow, !(push && full), "push into full queue")
    `FK_ASSERT(a_no_underflow, !(pop && empty), "pop from empty queue")

endmodule

FILE: src/fk_back.sv
// ----------------------------------------------------------------------------
// Back end, emitting frame origins
// Chains one Denavit-Hartenberg transform per cycle unless stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "arm_forward_kinematics_7dof_defines.svh"

module fk_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              empty,
    input  fk_pkg::sc_t                       pop_sc,
    output logic                              pop,
    input  logic [fk_pkg::LEN_W-1:0]          base_height,
    input  logic [fk_pkg::LEN_W-1:0]          upper_arm_length,
    input  logic [fk_pkg::LEN_W-1:0]          forearm_length,
    input  logic [fk_pkg::LEN_W-1:0]          tool_length,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [fk_pkg::FRAME_W-1:0]        frame_number,
    output logic signed [fk_pkg::POS_W-1:0]   pos_x,
    output logic signed [fk_pkg::POS_W-1:0]   pos_y,
    output logic signed [fk_pkg::POS_W-1:0]   pos_z,
    output logic                              last_frame
);
    import fk_pkg::*;

    logic signed [CS_W-1:0]  rot_reg  [0:2][0:2];
    logic signed [CS_W-1:0]  rot_next [0:2][0:2];
    logic signed [POS_W-1:0] pos_reg  [0:2];
    logic signed [POS_W-1:0] pos_next [0:2];
    logic                    valid_reg;
    logic [FRAME_W-1:0]      frame_reg;

    logic signed [CS_W-1:0]  a_v [0:2];
    logic signed [CS_W-1:0]  b_v [0:2];
    logic signed [CS_W-1:0]  e_v [0:2];
    logic signed [POS_W-1:0] p_v [0:2];
    logic signed [2*CS_W:0]  sum0 [0:2];
    logic signed [2*CS_W:0]  sum1 [0:2];
    logic signed [2*CS_W:0]  sum2 [0:2];
    logic signed [2*CS_W:0]  r0 [0:2];
    logic signed [2*CS_W:0]  r1 [0:2];
    logic signed [2*CS_W:0]  r2 [0:2];
    logic signed [LEN_W+CS_W:0] dprod [0:2];
    logic signed [LEN_W+CS_W:0] drnd [0:2];
    logic signed [POS_W+2:0] psum [0:2];
    logic [LEN_W-1:0]        d_len;
    logic signed [LEN_W:0]   d_s;
    logic                    first;
    twist_t                  tw;

    always_comb
    begin
        pop   = !empty && (!valid_reg || out_ready);
        first = pop_sc.joint == '0;
        tw    = twist_of(pop_sc.joint);
        unique case (pop_sc.joint)
            3'd0:    d_len = base_height;
            3'd2:    d_len = upper_arm_length;
            3'd4:    d_len = forearm_length;
            3'd6:    d_len = tool_length;
            default: d_len = '0;
        endcase
        d_s = $signed({1'b0, d_len});
        for (int r = 0; r < 3; r++)
        begin
            a_v[r] = first ? ((r == 0) ? ONE_Q16 : '0) : rot_reg[r][0];
            b_v[r] = first ? ((r == 1) ? ONE_Q16 : '0) : rot_reg[r][1];
            e_v[r] = first ? ((r == 2) ? ONE_Q16 : '0) : rot_reg[r][2];
            p_v[r] = first ? '0 : pos_reg[r];
            sum0[r] = (2*CS_W+1)'(pop_sc.cos_v * a_v[r]) + (2*CS_W+1)'(pop_sc.sin_v * b_v[r]);
            sum1[r] = (2*CS_W+1)'(pop_sc.sin_v * a_v[r]) - (2*CS_W+1)'(pop_sc.cos_v * b_v[r]);
            sum2[r] = (2*CS_W+1)'(pop_sc.cos_v * b_v[r]) - (2*CS_W+1)'(pop_sc.sin_v * a_v[r]);
            r0[r]   = (sum0[r] + (2*CS_W+1)'(32768)) >>> 16;
            r1[r]   = (sum1[r] + (2*CS_W+1)'(32768)) >>> 16;
            r2[r]   = (sum2[r] + (2*CS_W+1)'(32768)) >>> 16;
            rot_next[r][0] = r0[r][CS_W-1:0];
            unique case (tw)
                TWIST_POS:
                begin
                    rot_next[r][1] = e_v[r];
                    rot_next[r][2] = r1[r][CS_W-1:0];
                end
                TWIST_NEG:
                begin
                    rot_next[r][1] = -e_v[r];
                    rot_next[r][2] = r2[r][CS_W-1:0];
                end
                default:
                begin
                    rot_next[r][1] = r2[r][CS_W-1:0];
                    rot_next[r][2] = e_v[r];
                end
            endcase
            dprod[r] = (LEN_W+CS_W+1)'(d_s * e_v[r]);
            drnd[r]  = (dprod[r] + (LEN_W+CS_W+1)'(32768)) >>> 16;
            psum[r]  = (POS_W+3)'(p_v[r]) + drnd[r][POS_W+2:0];
            priority if (psum[r] > (POS_W+3)'(POS_MAX))
            begin
                pos_next[r] = POS_MAX;
            end
            else if (psum[r] < (POS_W+3)'(POS_MIN))
            begin
                pos_next[r] = POS_MIN;
            end
            else
            begin
                pos_next[r] = psum[r][POS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rot_reg   <= rot_next;
            pos_reg   <= pos_next;
            frame_reg <= pop_sc.joint;
        end
    end

    always_comb
    begin
        out_valid    = valid_reg;
        frame_number = frame_reg;
        pos_x        = pos_reg[0];
        pos_y        = pos_reg[1];
        pos_z        = pos_reg[2];
        last_frame   = frame_reg == LAST_JOINT;
    end

    `FK_ASSERT_IMPL(a_pop_room, pop, !valid_reg || out_ready, "result overwritten")
    `FK_ASSERT_IMPL(a_frame_order, pop && valid_reg && !last_frame, pop_sc.joint == frame_reg + 3'd1, "frame out of order")

endmodule

FILE: tb/tb_arm_forward_kinematics_7dof.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Forward kinematics testbench
// Drives joint-angle transactions and link-length writes into the seven-joint
// arm block, predicts every frame origin with an independent fixed-point
// CORDIC and DH chain, and checks each output transaction in order.
// ----------------------------------------------------------------------------

module tb_arm_forward_kinematics_7dof;
    import fk_pkg::*;

    typedef struct packed {
        logic [2:0]         frame;
        logic signed [18:0] px;
        logic signed [18:0] py;
        logic signed [18:0] pz;
        logic               last;
    } frame_pos_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [16:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [111:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tlast;

    logic [16:0] link_len [4];
    frame_pos_t  frames_due [$];
    int          fail_count;
    bit          hold_off;
    bit          steady_send;

    arm_forward_kinematics_7dof DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("arm_forward_kinematics_7dof verification failed");
        $finish;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_q16(longint v);
        return (v + 64'sd32768) >>> 16;
    endfunction

    function automatic longint clip_pos(longint v);
        if (v > 262143)
            return 262143;
        if (v < -262144)
            return -262144;
        return v;
    endfunction

    task automatic cordic_sin_cos(input logic signed [15:0] ang, output longint c,
                                  output longint s);
        longint x, y, z, xs, ys;
        bit     flip;
        x = 39797;
        y = 0;
        z = longint'(ang) * 8;
        flip = 1'b0;
        if (z > 102944)
        begin
            z -= 205887;
            flip = 1'b1;
        end
        else if (z < -102944)
        begin
            z += 205887;
            flip = 1'b1;
        end
        for (int i = 0; i < 16; i++)
        begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (z >= 0)
            begin
                x -= ys;
                y += xs;
                z -= longint'(atan_q16(i));
            end
            else
            begin
                x += ys;
                y -= xs;
                z += longint'(atan_q16(i));
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic predict_frames(input logic [111:0] angles);
        longint rot [3][3];
        longint pos [3];
        longint c, s, d, a, b, e;
        twist_t tw;
        frame_pos_t f;
        for (int r = 0; r < 3; r++)
        begin
            pos[r] = 0;
            for (int q = 0; q < 3; q++)
                rot[r][q] = (r == q) ? 65536 : 0;
        end
        for (int k = 0; k < 7; k++)
        begin
            cordic_sin_cos(angles[k*16 +: 16], c, s);
            case (k)
                0: d = link_len[REG_BASE];
                2: d = link_len[REG_UPPER];
                4: d = link_len[REG_FOREARM];
                6: d = link_len[REG_TOOL];
                default: d = 0;
            endcase
            for (int r = 0; r < 3; r++)
                pos[r] = clip_pos(pos[r] + round_q16(d * rot[r][2]));
            tw = twist_of(3'(k));
            for (int r = 0; r < 3; r++)
            begin
                a = rot[r][0];
                b = rot[r][1];
                e = rot[r][2];
                rot[r][0] = round_q16(c * a + s * b);
                if (tw == TWIST_POS)
                begin
                    rot[r][1] = e;
                    rot[r][2] = round_q16(s * a - c * b);
                end
                else if (tw == TWIST_NEG)
                begin
                    rot[r][1] = -e;
                    rot[r][2] = round_q16(c * b - s * a);
                end
                else
                begin
                    rot[r][1] = round_q16(c * b - s * a);
                    rot[r][2] = e;
                end
            end
            f.frame = 3'(k);
            f.px = 19'(pos[0]);
            f.py = 19'(pos[1]);
            f.pz = 19'(pos[2]);
            f.last = (3'(k) == LAST_JOINT);
            frames_due.push_back(f);
        end
    endtask

    task automatic send_angles(input logic [111:0] angles);
        int gap;
        gap = steady_send ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= angles;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_frames(angles);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_link(input logic [1:0] idx, input logic [16:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        link_len[idx] = val;
        @(posedge clk);
    endtask

    function automatic logic [15:0] rand_angle();
        return 16'($urandom);
    endfunction

    function automatic logic [111:0] rand_pose();
        logic [111:0] v;
        for (int k = 0; k < 7; k++)
            v[k*16 +: 16] = ($urandom_range(0, 3) == 0) ? rand_angle()
                : 16'($signed($urandom_range(0, 51472)) - 25736);
        return v;
    endfunction

    task automatic test_default_lengths();
        logic [111:0] v;
        send_angles('0);
        for (int j = 0; j < 7; j++)
        begin
            v = '0;
            v[j*16 +: 16] = 16'sd12868;
            send_angles(v);
            v[j*16 +: 16] = -16'sd12868;
            send_angles(v);
        end
        send_angles({7{16'sd25736}});
        send_angles({7{-16'sd25736}});
        send_angles({7{16'h7FFF}});
        send_angles({7{16'h8000}});
        send_angles({7{16'sd12869}});
        send_angles({7{-16'sd12869}});
        send_angles({7{16'hFFFF}});
        wait_drained();
    endtask

    task automatic test_extreme_lengths();
        for (int i = 0; i < 4; i++)
            write_link(2'(i), 17'h1FFFF);
        send_angles('0);
        send_angles({16'd0, 16'd0, 16'd0, 16'd0, 16'sd12868, 16'd0, 16'd0});
        for (int n = 0; n < 8; n++)
            send_angles(rand_pose());
        wait_drained();
        for (int i = 0; i < 4; i++)
            write_link(2'(i), 17'd0);
        send_angles('0);
        send_angles(rand_pose());
        wait_drained();
    endtask

    task automatic test_random_poses(input int count);
        for (int n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
            begin
                wait_drained();
                for (int i = 0; i < 4; i++)
                    write_link(2'(i), 17'($urandom));
            end
            steady_send = (n % 60) >= 45;
            send_angles(rand_pose());
        end
        steady_send = 1'b0;
        wait_drained();
    endtask

    task automatic test_back_pressure();
        hold_off = 1'b1;
        steady_send = 1'b1;
        for (int n = 0; n < 12; n++)
            send_angles(rand_pose());
        steady_send = 1'b0;
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        fail_count = 0;
        hold_off = 1'b0;
        steady_send = 1'b0;
        link_len[REG_BASE]    = BASE_RST;
        link_len[REG_UPPER]   = UPPER_RST;
        link_len[REG_FOREARM] = FOREARM_RST;
        link_len[REG_TOOL]    = TOOL_RST;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_lengths();
        test_extreme_lengths();
        test_back_pressure();
        test_random_poses(170);
        if (fail_count == 0)
            $display("arm_forward_kinematics_7dof verification clean");
        else
            $display("arm_forward_kinematics_7dof verification failed");
        $finish;
    end

    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            if (stall == 0)
                m_axis_tready <= 1'b1;
            else
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        frame_pos_t want;
        frame_pos_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.frame = m_axis_tdata[2:0];
            got.px    = m_axis_tdata[21:3];
            got.py    = m_axis_tdata[40:22];
            got.pz    = m_axis_tdata[59:41];
            got.last  = m_axis_tlast;
            if (frames_due.size() == 0)
            begin
                $display("%0t: unexpected frame transaction %h", $time, m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = frames_due.pop_front();
                if (got.frame !== want.frame || got.px !== want.px
                    || got.py !== want.py || got.pz !== want.pz
                    || got.last !== want.last || m_axis_tdata[63:60] !== 4'd0)
                begin
                    $display("%0t: expected frame %0d x %0d y %0d z %0d last %0b",
                             $time, want.frame, want.px, want.py, want.pz, want.last);
                    $display("%0t: actual   frame %0d x %0d y %0d z %0d last %0b",
                             $time, got.frame, got.px, got.py, got.pz, got.last);
                    fail_count++;
                end
            end
        end
    end

endmodule

FILE: sim.f
+incdir+src
src/fk_pkg.sv
src/fk_cordic.sv
src/fk_front.sv
src/fk_queue.sv
src/fk_back.sv
src/arm_forward_kinematics_7dof.sv
tb/tb_arm_forward_kinematics_7dof.sv
